[hdl/copt_pkg.sv]
package copt_pkg;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HDR,
		PH_DHI,
		PH_DLO,
		PH_LHI,
		PH_LLO,
		PH_VAL
	} phase_t;

	localparam logic [2:0] EV_HDR   = 3'd0;
	localparam logic [2:0] EV_OPT   = 3'd1;
	localparam logic [2:0] EV_VAL   = 3'd2;
	localparam logic [2:0] EV_END   = 3'd3;
	localparam logic [2:0] EV_NONE  = 3'd4;
	localparam logic [2:0] EV_BAD   = 3'd5;
	localparam logic [2:0] EV_TRUNC = 3'd6;

	localparam logic [3:0] EXT1_CODE = 4'd13;
	localparam logic [3:0] EXT2_CODE = 4'd14;
	localparam logic [3:0] BAD_CODE  = 4'd15;

	localparam logic [16:0] EXT1_OFFSET = 17'd13;
	localparam logic [16:0] EXT2_OFFSET = 17'd269;

	localparam logic [7:0] END_MARKER = 8'hFF;

endpackage

[hdl/coap_option_parser.sv]
// Option parser for the CoAP message format. Bytes enter one per cycle from the
// first option header onward, while in_stall is low, with first_byte on the
// first of them. Every byte taken while a parse is active yields exactly one
// result transfer: a header or extension byte absorbed, an option ready with its
// absolute number and value length, a value byte with an end mark, or an end
// event (marker seen, no options, malformed header, message truncated) carrying
// the message index just past the byte. Bytes that arrive with first_byte low
// while no parse is active are dropped without a result. The block sustains one
// byte per cycle while out_stall is low; a byte goes through the input register,
// then the result register, and the parse state updates as the result loads.
module coap_option_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        first_byte,
	input  logic        last_byte,
	input  logic [15:0] base_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_res,
	output logic [15:0] option_number,
	output logic [16:0] option_length,
	output logic [7:0]  value_byte,
	output logic        value_end,
	output logic [15:0] payload_index
);
	import copt_pkg::*;

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        first_s1;
	logic        last_s1;
	logic [15:0] base_s1;

	phase_t      phase_q, phase_d;
	logic [15:0] delta_q, delta_d;
	logic [7:0]  nibbles_q, nibbles_d;
	logic [7:0]  num_hi_q, num_hi_d;
	logic [7:0]  len_hi_q, len_hi_d;
	logic [16:0] remain_q, remain_d;
	logic [15:0] pos_q, pos_d;
	logic [15:0] pend_q, pend_d;

	logic        out_valid_q;
	logic [2:0]  event_q;
	logic [15:0] number_q;
	logic [16:0] length_q;
	logic [7:0]  vbyte_q;
	logic        vend_q;
	logic [15:0] index_q;

	logic        can_take;
	logic        in_fire;
	logic        fire_s1;
	logic        produce;
	logic        load_out;

	logic [2:0]  ev;
	logic [15:0] num;
	logic [16:0] len;
	logic [7:0]  vb;
	logic        ve;
	logic        take_hdr;
	logic        do_resolve;
	logic [3:0]  res_ln;
	logic [15:0] res_pn;
	logic        do_finish;
	logic [16:0] fin_len;
	logic [15:0] fin_pn;
	logic [15:0] delta_eff;
	logic [16:0] remain_dec;

	assign can_take = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !can_take;
	assign in_fire  = in_valid && !in_stall;
	assign fire_s1  = valid_s1 && can_take;
	assign load_out = fire_s1 && produce;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			data_s1  <= data_byte;
			first_s1 <= first_byte;
			last_s1  <= last_byte;
			base_s1  <= base_index;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		delta_d    = first_s1 ? '0 : delta_q;
		nibbles_d  = nibbles_q;
		num_hi_d   = num_hi_q;
		len_hi_d   = len_hi_q;
		remain_d   = remain_q;
		pos_d      = pos_q;
		pend_d     = pend_q;
		ev         = EV_HDR;
		num        = '0;
		len        = '0;
		vb         = '0;
		ve         = 1'b0;
		produce    = 1'b1;
		take_hdr   = 1'b0;
		do_resolve = 1'b0;
		res_ln     = '0;
		res_pn     = '0;
		do_finish  = 1'b0;
		fin_len    = '0;
		fin_pn     = '0;
		delta_eff  = first_s1 ? '0 : delta_q;
		remain_dec = (remain_q != '0) ? remain_q - 17'd1 : '0;

		if (first_s1) begin
			pos_d = base_s1 + 16'd1;
			if (data_s1 == END_MARKER || last_s1) begin
				ev      = EV_NONE;
				phase_d = PH_IDLE;
			end else begin
				take_hdr = 1'b1;
			end
		end else if (phase_q == PH_IDLE) begin
			produce = 1'b0;
		end else begin
			pos_d = pos_q + 16'd1;
			case (phase_q)
				PH_HDR: begin
					if (data_s1 == END_MARKER) begin
						ev      = EV_END;
						phase_d = PH_IDLE;
					end else begin
						take_hdr = 1'b1;
					end
				end
				PH_DHI: begin
					num_hi_d = data_s1;
					phase_d  = PH_DLO;
				end
				PH_DLO: begin
					do_resolve = 1'b1;
					res_ln     = nibbles_q[3:0];
					if (nibbles_q[7:4] == EXT1_CODE) begin
						res_pn = delta_q + {8'd0, data_s1} + EXT1_OFFSET[15:0];
					end else begin
						res_pn = delta_q + {num_hi_q, data_s1} + EXT2_OFFSET[15:0];
					end
				end
				PH_LHI: begin
					len_hi_d = data_s1;
					phase_d  = PH_LLO;
				end
				PH_LLO: begin
					do_finish = 1'b1;
					fin_pn    = pend_q;
					if (nibbles_q[3:0] == EXT1_CODE) begin
						fin_len = {9'd0, data_s1} + EXT1_OFFSET;
					end else begin
						fin_len = {1'b0, len_hi_q, data_s1} + EXT2_OFFSET;
					end
				end
				PH_VAL: begin
					vb       = data_s1;
					ev       = EV_VAL;
					remain_d = remain_dec;
					if (remain_dec == '0) begin
						ve      = 1'b1;
						phase_d = PH_HDR;
					end
				end
				default: begin
					produce = 1'b0;
					phase_d = PH_IDLE;
				end
			endcase
		end

		if (take_hdr) begin
			nibbles_d = data_s1;
			case (data_s1[7:4])
				BAD_CODE: begin
					ev      = EV_BAD;
					phase_d = PH_IDLE;
				end
				EXT1_CODE: begin
					phase_d = PH_DLO;
				end
				EXT2_CODE: begin
					phase_d = PH_DHI;
				end
				default: begin
					do_resolve = 1'b1;
					res_ln     = data_s1[3:0];
					res_pn     = delta_eff + {12'd0, data_s1[7:4]};
				end
			endcase
		end

		if (do_resolve) begin
			pend_d = res_pn;
			case (res_ln)
				BAD_CODE: begin
					ev      = EV_BAD;
					phase_d = PH_IDLE;
				end
				EXT1_CODE: begin
					phase_d = PH_LLO;
				end
				EXT2_CODE: begin
					phase_d = PH_LHI;
				end
				default: begin
					do_finish = 1'b1;
					fin_pn    = res_pn;
					fin_len   = {13'd0, res_ln};
				end
			endcase
		end

		if (do_finish) begin
			delta_d = fin_pn;
			ev      = EV_OPT;
			num     = fin_pn;
			len     = fin_len;
			if (fin_len == '0) begin
				phase_d = PH_HDR;
			end else begin
				remain_d = fin_len;
				phase_d  = PH_VAL;
			end
		end

		if (produce && last_s1 && (ev == EV_HDR || ev == EV_OPT || ev == EV_VAL)) begin
			if (phase_d != PH_HDR) begin
				ev  = EV_TRUNC;
				num = '0;
				len = '0;
				vb  = '0;
				ve  = 1'b0;
			end
			phase_d = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			delta_q   <= '0;
			nibbles_q <= '0;
			num_hi_q  <= '0;
			len_hi_q  <= '0;
			remain_q  <= '0;
			pos_q     <= '0;
			pend_q    <= '0;
		end else if (fire_s1) begin
			phase_q   <= phase_d;
			delta_q   <= delta_d;
			nibbles_q <= nibbles_d;
			num_hi_q  <= num_hi_d;
			len_hi_q  <= len_hi_d;
			remain_q  <= remain_d;
			pos_q     <= pos_d;
			pend_q    <= pend_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			event_q  <= ev;
			number_q <= (ev == EV_OPT) ? num : '0;
			length_q <= (ev == EV_OPT) ? len : '0;
			vbyte_q  <= (ev == EV_VAL) ? vb : '0;
			vend_q   <= (ev == EV_VAL) ? ve : 1'b0;
			index_q  <= (ev == EV_END || ev == EV_NONE || ev == EV_BAD || ev == EV_TRUNC) ?
				pos_d : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_res     = event_q;
	assign option_number = number_q;
	assign option_length = length_q;
	assign value_byte    = vbyte_q;
	assign value_end     = vend_q;
	assign payload_index = index_q;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("Input stalled with an empty input register.");

	a_value_phase_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_VAL |-> remain_q != '0)
		else $error("Value phase entered with no value bytes remaining.");

	a_end_mark_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && value_end |-> event_res == EV_VAL)
		else $error("End mark shown with an event other than a value byte.");

	a_out_drains: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !load_out |=> !out_valid)
		else $error("Result transfer was repeated.");

endmodule
